// ===== rtl/binary_palette_nearest_match_defines.svh =====
// Assertion macros shared by the checker of the palette nearest match block.
`ifndef BINARY_PALETTE_NEAREST_MATCH_DEFINES_SVH
`define BINARY_PALETTE_NEAREST_MATCH_DEFINES_SVH

// The property is checked on every clock edge outside reset.
`define BPNM_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// The property is checked on every clock edge, reset included.
`define BPNM_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/bpnm_pkg.sv =====
// Package with the constants, codes and types of the palette nearest match block.
`default_nettype none

package bpnm_pkg;

    localparam int DEF_MAX_ENTRIES = 256;
    localparam int MAX_BANDS       = 32;

    localparam int DATA_W     = 32;
    localparam int SLOT_W     = 8;
    localparam int DIST_W     = 6;
    localparam int OUT_W      = 17;
    localparam int EC_W       = 9;
    localparam int BC_W       = 6;
    localparam int OFS_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 24;

    localparam logic [EC_W-1:0]  ENTRY_COUNT_RESET  = EC_W'(2);
    localparam logic [BC_W-1:0]  BAND_COUNT_RESET   = BC_W'(1);
    localparam logic [OFS_W-1:0] INDEX_OFFSET_RESET = '0;

    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ENTRY_COUNT  = 2'd0,
        CFG_BAND_COUNT   = 2'd1,
        CFG_INDEX_OFFSET = 2'd2,
        CFG_WIDE_OUTPUT  = 2'd3
    } cfg_addr_t;

    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] bits;
        logic [DIST_W-1:0] best_dist;
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/binary_palette_nearest_match.sv =====
// Top level of the palette nearest match block: configuration, cell chain and output stage.
//
// Channel  Direction  Payload                                          Transaction
// s_       in         tuser op; tdata slot, entry bits, pixel bits     tvalid & tready
// m_       out        tdata color index (17 bits)                      tvalid & tready
// cfg_     in         register index, write data                       cfg_we
//
// One item enters per cycle while the chain is not stalled, and a query result is registered
// in each cell of the chain, one cell per palette entry, and then in the output stage.
// Loads travel the chain behind earlier queries, so every query sees the palette of its turn.
// A stalled result stalls the whole chain, and s_tready follows the output stage.
// Reset clears only the valid flags and the configuration registers; palette entries are undefined until loaded.
`default_nettype none

module binary_palette_nearest_match #(
    parameter int MAX_ENTRIES = bpnm_pkg::DEF_MAX_ENTRIES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: entry_slot, entry_bits, pixel_bits.
    input  wire logic [bpnm_pkg::S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: op.
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // Fields from bit 0: color_index, then zero fill.
    output logic [bpnm_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [bpnm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [bpnm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bpnm_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int LIM_W = $clog2(MAX_ENTRIES + 1);

    logic [EC_W-1:0]   entry_count_reg;
    logic [BC_W-1:0]   band_count_reg;
    logic [OFS_W-1:0]  index_offset_reg;
    logic              wide_output_reg;

    logic [LIM_W-1:0]  entry_limit;
    logic [DATA_W-1:0] band_mask;
    logic [31:0]       limit_full;
    logic [BC_W-1:0]   bands_sat;
    logic              en;

    item_t             chain     [0:MAX_ENTRIES];
    logic [IDX_W-1:0]  idx_chain [0:MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg  <= ENTRY_COUNT_RESET;
            band_count_reg   <= BAND_COUNT_RESET;
            index_offset_reg <= INDEX_OFFSET_RESET;
            wide_output_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_ENTRY_COUNT:  entry_count_reg  <= cfg_wdata[EC_W-1:0];
                CFG_BAND_COUNT:   band_count_reg   <= cfg_wdata[BC_W-1:0];
                CFG_INDEX_OFFSET: index_offset_reg <= cfg_wdata[OFS_W-1:0];
                CFG_WIDE_OUTPUT:  wide_output_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        limit_full = (entry_count_reg == '0) ? 32'd1 : 32'(entry_count_reg);
        if (limit_full > 32'(MAX_ENTRIES)) begin
            limit_full = 32'(MAX_ENTRIES);
        end
        entry_limit = LIM_W'(limit_full);
        bands_sat = (32'(band_count_reg) > 32'(MAX_BANDS)) ? BC_W'(MAX_BANDS)
                                                          : band_count_reg;
        for (int i = 0; i < DATA_W; i++) begin
            band_mask[i] = 32'(i) < 32'(bands_sat);
        end
    end

    always_comb begin
        chain[0].valid     = s_tvalid;
        chain[0].op        = op_t'(s_tuser);
        chain[0].slot      = s_tdata[SLOT_W-1:0];
        chain[0].bits      = (op_t'(s_tuser) == OP_QUERY) ? s_tdata[SLOT_W+DATA_W +: DATA_W]
                                                           : s_tdata[SLOT_W +: DATA_W];
        chain[0].best_dist = DIST_NONE;
        idx_chain[0]       = '0;
    end

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        bpnm_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .CELL_IDX    (k)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (en),
            .entry_limit (entry_limit),
            .band_mask   (band_mask),
            .item_in     (chain[k]),
            .idx_in      (idx_chain[k]),
            .item_out    (chain[k+1]),
            .idx_out     (idx_chain[k+1])
        );
    end

    bpnm_result #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_result (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_in      (chain[MAX_ENTRIES]),
        .idx_in       (idx_chain[MAX_ENTRIES]),
        .index_offset (index_offset_reg),
        .wide_output  (wide_output_reg),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .en           (en)
    );

    assign s_tready = en;

endmodule

`default_nettype wire

// ===== rtl/bpnm_cell.sv =====
// One palette cell: holds one entry, stores loads aimed at it and updates the running best match.
`default_nettype none

module bpnm_cell #(
    parameter int MAX_ENTRIES = bpnm_pkg::DEF_MAX_ENTRIES,
    parameter int CELL_IDX    = 0,
    localparam int IDX_W      = $clog2(MAX_ENTRIES),
    localparam int LIM_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic [LIM_W-1:0]            entry_limit,
    input  wire logic [bpnm_pkg::DATA_W-1:0] band_mask,
    input  wire bpnm_pkg::item_t             item_in,
    input  wire logic [IDX_W-1:0]            idx_in,
    output bpnm_pkg::item_t                  item_out,
    output logic [IDX_W-1:0]                 idx_out
);
    import bpnm_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    item_t             item_reg;
    logic [IDX_W-1:0]  idx_reg;
    item_t             item_next;
    logic [IDX_W-1:0]  idx_next;
    logic [DIST_W-1:0] cell_dist;
    logic              hit;
    logic              active;
    logic              better;

    always_comb begin
        hit       = item_in.valid && (item_in.op == OP_LOAD)
                    && (32'(item_in.slot) == 32'(CELL_IDX));
        active    = LIM_W'(CELL_IDX) < entry_limit;
        cell_dist = DIST_W'($countones((item_in.bits ^ entry_reg) & band_mask));
        better    = (item_in.op == OP_QUERY) && active && (cell_dist < item_in.best_dist);
        item_next = item_in;
        idx_next  = idx_in;
        if (better) begin
            item_next.best_dist = cell_dist;
            idx_next            = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (en && hit) begin
            entry_reg <= item_in.bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (en) begin
            item_reg <= item_next;
            idx_reg  <= idx_next;
        end
    end

    assign item_out = item_reg;
    assign idx_out  = idx_reg;

endmodule

`default_nettype wire

// ===== rtl/bpnm_result.sv =====
// Output stage: adds the offset to the winning index, wraps it and holds the result transaction.
`default_nettype none

module bpnm_result #(
    parameter int MAX_ENTRIES = bpnm_pkg::DEF_MAX_ENTRIES,
    localparam int IDX_W      = $clog2(MAX_ENTRIES)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire bpnm_pkg::item_t                item_in,
    input  wire logic [IDX_W-1:0]               idx_in,
    input  wire logic [bpnm_pkg::OFS_W-1:0]     index_offset,
    input  wire logic                           wide_output,
    input  wire logic                           m_tready,
    output logic                                m_tvalid,
    output logic [bpnm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                en
);
    import bpnm_pkg::*;

    logic                 valid_reg;
    logic [M_TDATA_W-1:0] tdata_reg;
    logic [OFS_W-1:0]     sum;
    logic [OUT_W-1:0]     color;

    always_comb begin
        sum   = index_offset + OFS_W'(idx_in);
        color = wide_output ? {sum[OFS_W-1], sum} : OUT_W'(sum[7:0]);
        en    = !valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= item_in.valid && (item_in.op == OP_QUERY);
            tdata_reg <= M_TDATA_W'(color);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/bpnm_checker.sv =====
// Port checker of the palette nearest match block and its bind to the top level.
`default_nettype none

`include "binary_palette_nearest_match_defines.svh"

module bpnm_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [bpnm_pkg::M_TDATA_W-1:0]   m_tdata
);

    `BPNM_CHECK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result not held")
    `BPNM_CHECK(a_pad_zero, m_tvalid |-> m_tdata[23:17] == 7'd0, "result fill bits not zero")
    `BPNM_CHECK(a_ready_free, (!m_tvalid || m_tready) |-> s_tready, "input stalled with free output")
    `BPNM_CHECK_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind binary_palette_nearest_match bpnm_checker u_bpnm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire

// ===== tb/sv/tb_binary_palette_nearest_match.sv =====
// Self-checking testbench of the palette nearest match block with directed and random traffic.
`timescale 1ns / 1ps

module tb_binary_palette_nearest_match;
    import bpnm_pkg::*;

    localparam int PALETTE_DEPTH = DEF_MAX_ENTRIES;
    localparam int CHAIN_LATENCY = DEF_MAX_ENTRIES + 1;
    localparam int RUN_LIMIT     = 500000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    wire                    s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    wire                    m_tvalid;
    logic                   m_tready  = 1'b0;
    wire  [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    logic [DATA_W-1:0]  palette_copy [PALETTE_DEPTH];
    bit                 palette_loaded [PALETTE_DEPTH];
    logic [EC_W-1:0]    cfg_entries = ENTRY_COUNT_RESET;
    logic [BC_W-1:0]    cfg_bands   = BAND_COUNT_RESET;
    logic [OFS_W-1:0]   cfg_offset  = INDEX_OFFSET_RESET;
    logic               cfg_wide    = 1'b0;

    logic [OUT_W-1:0]   color_expected [$];
    int                 cycle_count  = 0;
    int                 fault_count  = 0;
    int                 load_count   = 0;
    int                 query_count  = 0;
    int                 result_count = 0;
    int                 setting_count = 0;
    int                 stall_left   = 0;
    bit                 gaps_on      = 1'b0;
    bit                 stalls_on    = 1'b0;

    binary_palette_nearest_match dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic int search_span();
        if (cfg_entries == 0) begin
            return 1;
        end
        if (cfg_entries > PALETTE_DEPTH) begin
            return PALETTE_DEPTH;
        end
        return int'(cfg_entries);
    endfunction

    function automatic bit palette_ready();
        int span;
        span = search_span();
        for (int k = 0; k < span; k++) begin
            if (!palette_loaded[k]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] nearest_color(logic [DATA_W-1:0] pix);
        int                span;
        int                bands;
        int                diff_count;
        int                best;
        int                best_dist;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] diff;
        logic [OFS_W-1:0]  sum;
        span = search_span();
        bands = (cfg_bands > MAX_BANDS) ? MAX_BANDS : int'(cfg_bands);
        mask = (bands == DATA_W) ? '1 : ((DATA_W'(1) << bands) - DATA_W'(1));
        best = 0;
        best_dist = DATA_W + 1;
        for (int k = 0; k < span; k++) begin
            diff = (pix ^ palette_copy[k]) & mask;
            diff_count = 0;
            for (int i = 0; i < DATA_W; i++) begin
                diff_count += diff[i];
            end
            if (diff_count < best_dist) begin
                best_dist = diff_count;
                best = k;
            end
        end
        sum = cfg_offset + OFS_W'(best);
        if (!cfg_wide) begin
            return {9'b0, sum[7:0]};
        end
        return {sum[OFS_W-1], sum};
    endfunction

    function automatic logic [DATA_W-1:0] probe_pixel();
        case ($urandom_range(3))
            0: return $urandom;
            1, 2: return palette_copy[$urandom_range(search_span() - 1)]
                         ^ ($urandom & $urandom & $urandom);
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    task automatic send_item(op_t op, logic [SLOT_W-1:0] slot,
                             logic [DATA_W-1:0] ebits, logic [DATA_W-1:0] pbits);
        int gap;
        gap = (gaps_on && $urandom_range(3) == 0) ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pbits, ebits, slot};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_LOAD) begin
            palette_copy[slot] = ebits;
            palette_loaded[slot] = 1'b1;
            load_count++;
        end else begin
            color_expected.push_back(nearest_color(pbits));
            query_count++;
        end
    endtask

    task automatic send_load(logic [SLOT_W-1:0] slot, logic [DATA_W-1:0] ebits);
        send_item(OP_LOAD, slot, ebits, $urandom);
    endtask

    task automatic send_query(logic [DATA_W-1:0] pbits);
        send_item(OP_QUERY, SLOT_W'($urandom), $urandom, pbits);
    endtask

    task automatic wait_results_done(bit flush_chain);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (color_expected.size() != 0) @(posedge aclk);
        if (flush_chain) begin
            repeat (CHAIN_LATENCY + 8) @(posedge aclk);
        end
    endtask

    task automatic write_reg(cfg_addr_t addr, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            CFG_ENTRY_COUNT:  cfg_entries = value[EC_W-1:0];
            CFG_BAND_COUNT:   cfg_bands = value[BC_W-1:0];
            CFG_INDEX_OFFSET: cfg_offset = value[OFS_W-1:0];
            CFG_WIDE_OUTPUT:  cfg_wide = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(int entries, int bands, logic [OFS_W-1:0] offset, bit wide);
        wait_results_done(1'b1);
        write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(entries));
        write_reg(CFG_BAND_COUNT, CFG_DATA_W'(bands));
        write_reg(CFG_INDEX_OFFSET, offset);
        write_reg(CFG_WIDE_OUTPUT, CFG_DATA_W'(wide));
        setting_count++;
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (stalls_on && $urandom_range(4) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (color_expected.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("Unexpected result transaction: color_index %h", m_tdata[OUT_W-1:0]);
                end
            end else begin
                want = color_expected.pop_front();
                if (m_tdata[OUT_W-1:0] !== want) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("color_index mismatch: expected %h, actual %h",
                                 want, m_tdata[OUT_W-1:0]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_load(0, 32'hFFFF_FFFE);
        send_load(1, 32'h0000_0001);
        send_query(32'h0000_0000);
        send_query(32'h0000_0001);
        send_query(32'hFFFF_FFFF);
        send_query(32'hFFFF_FFFE);
    endtask

    task automatic test_directed_extremes();
        set_all(4, 32, 16'h0000, 1'b0);
        send_load(0, 32'h0000_0000);
        send_load(1, 32'hFFFF_FFFF);
        send_load(2, 32'h0000_FFFF);
        send_load(3, 32'h0000_FFFF);
        send_load(255, 32'hFFFF_FFFF);
        send_query(32'hFFFF_FFFF);
        send_query(32'h0000_0000);
        send_query(32'h0000_FFFF);
        send_query(32'h8000_FFFF);
        // With no bands compared every distance is zero and entry zero wins.
        set_all(4, 0, 16'h8000, 1'b1);
        send_query($urandom);
        set_all(0, 63, 16'h7FFF, 1'b1);
        send_query($urandom);
        set_all(2, 32, 16'h7FFF, 1'b1);
        send_query(32'hFFFF_FFFF);
        set_all(2, 32, 16'hFFFF, 1'b0);
        send_query(32'hFFFF_FFFF);
        send_query(32'h0000_0000);
    endtask

    task automatic test_full_palette();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        set_all(256, 8, 16'h0000, 1'b1);
        for (int k = 0; k < PALETTE_DEPTH; k++) begin
            send_load(SLOT_W'(k), $urandom & $urandom);
        end
        repeat (16) send_query(probe_pixel());
        set_all(511, 32, 16'hFF00, 1'b0);
        repeat (8) send_query(probe_pixel());
        set_all(257, 5, 16'h8000, 1'b1);
        repeat (8) send_query(probe_pixel());
    endtask

    task automatic test_random_phases();
        int               entries;
        int               bands;
        logic [OFS_W-1:0] offset;
        logic [DATA_W-1:0] ebits;
        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(6))
                0: entries = $urandom_range(0, 2);
                1, 2: entries = $urandom_range(3, 16);
                3: entries = $urandom_range(17, 255);
                4: entries = 256;
                default: entries = $urandom_range(257, 511);
            endcase
            case ($urandom_range(5))
                0: bands = $urandom_range(0, 1);
                1: bands = 32;
                2: bands = $urandom_range(33, 63);
                default: bands = $urandom_range(2, 31);
            endcase
            case ($urandom_range(3))
                0: offset = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                1: offset = OFS_W'($urandom_range(0, 15) - 8);
                default: offset = OFS_W'($urandom_range(0, 65535));
            endcase
            set_all(entries, bands, offset, $urandom_range(1));
            gaps_on = (p % 4 == 0) || (p % 4 == 2);
            stalls_on = (p % 4 == 0) || (p % 4 == 3);
            for (int i = 0; i < 60; i++) begin
                if (i == 30) begin
                    wait_results_done(1'b0);
                end
                if ($urandom_range(3) == 0 || !palette_ready()) begin
                    ebits = $urandom_range(1) ? $urandom
                          : palette_copy[$urandom_range(PALETTE_DEPTH - 1)]
                            ^ ($urandom & $urandom & $urandom);
                    send_load(SLOT_W'($urandom_range(PALETTE_DEPTH - 1)), ebits);
                end else begin
                    send_query(probe_pixel());
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed_extremes();
        test_full_palette();
        test_random_phases();
        wait_results_done(1'b1);
        $display("Sent %0d palette loads and %0d queries over %0d register settings.",
                 load_count, query_count, setting_count);
        $display("Checked %0d result transactions, %0d faults found.",
                 result_count, fault_count);
        if (fault_count == 0 && color_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
